[design/fcalloc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fcalloc_pkg;

   localparam int CFG_CNT_W      = 9;
   localparam int CFG_SIZE_W     = 16;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 1;
   localparam int CMD_W          = 2;
   localparam int IDX_W          = 8;
   localparam int STATUS_W       = 2;
   localparam int OFF_W          = 24;
   localparam int MAX_CHUNKS_DEF = 256;

   localparam logic [CFG_CNT_W-1:0]  CHUNK_COUNT_RST = 9'd256;
   localparam logic [CFG_SIZE_W-1:0] CHUNK_SIZE_RST  = 16'd64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHUNK_COUNT = 1'b0,
      CSR_CHUNK_SIZE  = 1'b1
   } csr_index_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_REINIT = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NONE_USED = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

endpackage

`default_nettype wire

[design/fcalloc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module fcalloc_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/free_list_chunk_allocator.sv]
// Fixed-size chunk pool allocator with a LIFO free list held in a link RAM.
// Input channel req_*: cmd (allocate, free, reinitialize) and chunk_index,
// moved by a valid/ready transfer. Result channel rsp_*: one result per
// request with status, alloc_index, byte_offset, used_count and is_empty.
// Configuration port csr_*: index 0 writes chunk_count, index 1 chunk_size;
// a write takes effect at the clock edge where csr_write_enable is high.
// Throughput: one request at a time. Free, unused commands and a refused
// allocate go from the request transfer through an execute state to the
// result; a granted allocate adds a load state (one link RAM read plus head
// update, with the offset multiply alongside).
// Reinitialize rewrites every link RAM entry, one per cycle, and then
// answers. A new request is taken only once the previous result has been
// taken by the receiver and the block is back in idle.
// Reset: synchronous, active high. After reset the block rebuilds the chain
// in the link RAM with req_ready low; csr writes are taken during that
// time. While the receiver stalls, the block holds the result in its output
// registers and keeps req_ready low until the result transfer.
`timescale 1ns / 1ps
`default_nettype none

module free_list_chunk_allocator #(
   parameter int MAX_CHUNKS = fcalloc_pkg::MAX_CHUNKS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [fcalloc_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [fcalloc_pkg::IDX_W-1:0]      req_chunk_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [fcalloc_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [fcalloc_pkg::IDX_W-1:0]      rsp_alloc_index,
   output logic      [fcalloc_pkg::OFF_W-1:0]      rsp_byte_offset,
   output logic      [fcalloc_pkg::CFG_CNT_W-1:0]  rsp_used_count,
   output logic                                    rsp_is_empty,
   input  wire logic                               csr_write_enable,
   input  wire logic [fcalloc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fcalloc_pkg::CSR_DATA_W-1:0] csr_write_data
);

   import fcalloc_pkg::*;

   localparam int AW = $clog2(MAX_CHUNKS);
   localparam int LW = $clog2(MAX_CHUNKS + 1);
   localparam int CW = (LW > CFG_CNT_W) ? LW : CFG_CNT_W;
   localparam logic [LW-1:0] END_MARK = LW'(MAX_CHUNKS);
   localparam logic [CW-1:0] MAX_N    = CW'(MAX_CHUNKS);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_CNT_W-1:0]  count_ff, count_in;
   logic [CFG_SIZE_W-1:0] size_ff, size_in;
   logic [LW-1:0]         head_ff, head_in;
   logic [CFG_CNT_W-1:0]  used_ff, used_in;
   logic [LW-1:0]         sweep_ff, sweep_in;
   logic [CW-1:0]         build_n_ff, build_n_in;
   logic                  reinit_ff, reinit_in;
   cmd_type               cmd_ff, cmd_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   status_type            status_ff, status_in;
   logic [IDX_W-1:0]      alloc_ff, alloc_in;
   logic [OFF_W-1:0]      offset_ff, offset_in;

   logic [CW-1:0]    n_eff;
   logic [CW-1:0]    reset_n;
   logic [OFF_W-1:0] product;
   logic [LW-1:0]    sweep_next;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [LW-1:0]    ram_wdata;
   logic [LW-1:0]    ram_rdata;

   always_comb begin
      n_eff = CW'(count_ff);
      if (count_ff == '0) begin
         n_eff = CW'(1);
      end else if (CW'(count_ff) > MAX_N) begin
         n_eff = MAX_N;
      end
      reset_n = (CW'(CHUNK_COUNT_RST) > MAX_N) ? MAX_N : CW'(CHUNK_COUNT_RST);
   end

   assign product    = OFF_W'(head_ff) * OFF_W'(size_ff);
   assign sweep_next = sweep_ff + LW'(1);

   fcalloc_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_CHUNKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      size_in    = size_ff;
      head_in    = head_ff;
      used_in    = used_ff;
      sweep_in   = sweep_ff;
      build_n_in = build_n_ff;
      reinit_in  = reinit_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      alloc_in   = alloc_ff;
      offset_in  = offset_ff;
      ram_we     = 1'b0;
      ram_waddr  = sweep_ff[AW-1:0];
      ram_wdata  = (CW'(sweep_next) < build_n_ff) ? sweep_next : END_MARK;

      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHUNK_COUNT: count_in = csr_write_data[CFG_CNT_W-1:0];
            CSR_CHUNK_SIZE:  size_in  = csr_write_data[CFG_SIZE_W-1:0];
            default:         count_in = count_ff;
         endcase
      end

      unique case (state_ff)
         ST_SWEEP: begin
            ram_we   = 1'b1;
            sweep_in = sweep_next;
            if (sweep_ff == END_MARK - LW'(1)) begin
               head_in  = '0;
               used_in  = '0;
               state_in = reinit_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               idx_in   = req_chunk_index;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_OK;
            alloc_in  = '0;
            offset_in = '0;
            state_in  = ST_RESP;
            unique case (cmd_ff)
               CMD_ALLOC: begin
                  if (CW'(head_ff) >= n_eff || CW'(used_ff) >= n_eff) begin
                     status_in = STATUS_FULL;
                  end else begin
                     alloc_in  = IDX_W'(head_ff);
                     offset_in = product;
                     state_in  = ST_LOAD;
                  end
               end
               CMD_FREE: begin
                  priority if (used_ff == '0) begin
                     status_in = STATUS_NONE_USED;
                  end else if (CW'(idx_ff) >= n_eff) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(idx_ff);
                     ram_wdata = head_ff;
                     head_in   = LW'(idx_ff);
                     used_in   = used_ff - CFG_CNT_W'(1);
                  end
               end
               CMD_REINIT: begin
                  sweep_in   = '0;
                  build_n_in = n_eff;
                  reinit_in  = 1'b1;
                  state_in   = ST_SWEEP;
               end
               CMD_NOP: begin
                  status_in = STATUS_OK;
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
         ST_LOAD: begin
            head_in  = ram_rdata;
            used_in  = used_ff + CFG_CNT_W'(1);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               reinit_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         count_ff   <= CHUNK_COUNT_RST;
         size_ff    <= CHUNK_SIZE_RST;
         head_ff    <= '0;
         used_ff    <= '0;
         sweep_ff   <= '0;
         build_n_ff <= reset_n;
         reinit_ff  <= 1'b0;
         status_ff  <= STATUS_OK;
         alloc_ff   <= '0;
         offset_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         size_ff    <= size_in;
         head_ff    <= head_in;
         used_ff    <= used_in;
         sweep_ff   <= sweep_in;
         build_n_ff <= build_n_in;
         reinit_ff  <= reinit_in;
         status_ff  <= status_in;
         alloc_ff   <= alloc_in;
         offset_ff  <= offset_in;
      end
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_status      = status_ff;
   assign rsp_alloc_index = alloc_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_used_count  = used_ff;
   assign rsp_is_empty    = (used_ff == '0);

endmodule

`default_nettype wire

[tb/sv/free_list_chunk_allocator_tb.sv]
`timescale 1ns / 1ps

module free_list_chunk_allocator_tb;
   import fcalloc_pkg::*;

   localparam int POOL_MAX = MAX_CHUNKS_DEF;
   localparam int END_MARK = POOL_MAX;

   typedef struct {
      status_type           status;
      logic [IDX_W-1:0]     index;
      logic [OFF_W-1:0]     offset;
      logic [CFG_CNT_W-1:0] used;
      logic                 is_empty;
   } pool_reply_type;

   typedef struct {
      bit                    is_csr;
      csr_index_type         csr_sel;
      logic [CSR_DATA_W-1:0] csr_data;
      cmd_type               cmd;
      logic [IDX_W-1:0]      idx;
      bit                    typed;
      pool_reply_type        want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CMD_W-1:0] req_cmd = '0;
   logic [IDX_W-1:0] req_chunk_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0] rsp_alloc_index;
   logic [OFF_W-1:0] rsp_byte_offset;
   logic [CFG_CNT_W-1:0] rsp_used_count;
   logic rsp_is_empty;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // predictor state
   logic [CFG_CNT_W-1:0] next_free [POOL_MAX];
   logic [CFG_CNT_W-1:0] free_head;
   logic [CFG_CNT_W-1:0] used_chunks;
   logic [CFG_CNT_W-1:0] chunk_count_cfg;
   logic [CFG_SIZE_W-1:0] chunk_size_cfg;

   pool_reply_type pending_replies[$];
   script_row_type script[$];
   int live_chunks[$];
   pool_reply_type blank_reply = '{STATUS_OK, '0, '0, '0, 1'b0};
   int tx_idle_pct = 37;
   int rx_idle_pct = 69;
   int errors = 0;

   free_list_chunk_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_chunk_index  (req_chunk_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_alloc_index  (rsp_alloc_index),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_used_count   (rsp_used_count),
      .rsp_is_empty     (rsp_is_empty),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   function automatic int active_chunks();
      int n;
      n = int'(chunk_count_cfg);
      if (n == 0) n = 1;
      if (n > POOL_MAX) n = POOL_MAX;
      return n;
   endfunction

   function automatic void rebuild_links();
      int n;
      n = active_chunks();
      for (int i = 0; i < POOL_MAX; i++) begin
         next_free[i] = (i + 1 < n) ? CFG_CNT_W'(i + 1) : CFG_CNT_W'(END_MARK);
      end
      free_head = '0;
      used_chunks = '0;
   endfunction

   function automatic pool_reply_type predict_pool(cmd_type cmd, logic [IDX_W-1:0] idx);
      pool_reply_type r;
      int n;
      n = active_chunks();
      r.status = STATUS_OK;
      r.index = '0;
      r.offset = '0;
      case (cmd)
         CMD_ALLOC: begin
            if (free_head >= n || used_chunks >= n) begin
               r.status = STATUS_FULL;
            end else begin
               r.index = free_head[IDX_W-1:0];
               free_head = next_free[r.index];
               used_chunks = used_chunks + 1'b1;
               r.offset = OFF_W'(r.index) * OFF_W'(chunk_size_cfg);
            end
         end
         CMD_FREE: begin
            if (used_chunks == 0) begin
               r.status = STATUS_NONE_USED;
            end else if (idx >= n) begin
               r.status = STATUS_RANGE;
            end else begin
               used_chunks = used_chunks - 1'b1;
               next_free[idx] = free_head;
               free_head = {1'b0, idx};
            end
         end
         CMD_REINIT: rebuild_links();
         default: ;
      endcase
      r.used = used_chunks;
      r.is_empty = (used_chunks == 0);
      return r;
   endfunction

   function automatic void add_req(cmd_type cmd, logic [IDX_W-1:0] idx);
      script_row_type row;
      row.is_csr = 1'b0;
      row.cmd = cmd;
      row.idx = idx;
      row.typed = 1'b0;
      script.push_back(row);
   endfunction

   function automatic void add_typed(cmd_type cmd, logic [IDX_W-1:0] idx, status_type st,
                                     int index, int offset, int used, bit is_empty);
      script_row_type row;
      row.is_csr = 1'b0;
      row.cmd = cmd;
      row.idx = idx;
      row.typed = 1'b1;
      row.want.status = st;
      row.want.index = IDX_W'(index);
      row.want.offset = OFF_W'(offset);
      row.want.used = CFG_CNT_W'(used);
      row.want.is_empty = is_empty;
      script.push_back(row);
   endfunction

   function automatic void add_csr(csr_index_type sel, logic [CSR_DATA_W-1:0] data);
      script_row_type row;
      row.is_csr = 1'b1;
      row.csr_sel = sel;
      row.csr_data = data;
      script.push_back(row);
   endfunction

   task automatic send_request(cmd_type cmd, logic [IDX_W-1:0] idx, bit typed,
                               pool_reply_type want);
      pool_reply_type r;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_chunk_index <= idx;
      do @(posedge clock); while (!req_ready);
      r = predict_pool(cmd, idx);
      pending_replies.push_back(typed ? want : r);
      if (cmd == CMD_ALLOC && r.status == STATUS_OK) begin
         live_chunks.push_back(int'(r.index));
      end else if (cmd == CMD_FREE && r.status == STATUS_OK) begin
         for (int k = 0; k < live_chunks.size(); k++) begin
            if (live_chunks[k] == idx) begin
               live_chunks.delete(k);
               break;
            end
         end
      end else if (cmd == CMD_REINIT) begin
         live_chunks.delete();
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type sel, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_write_data <= data;
      @(posedge clock);
      if (sel == CSR_CHUNK_COUNT) chunk_count_cfg = data[CFG_CNT_W-1:0];
      else chunk_size_cfg = data;
   endtask

   // result checking
   always @(posedge clock) begin : rsp_check
      pool_reply_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $error("result transfer with nothing outstanding");
            errors++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_alloc_index !== want.index) begin
               $error("alloc_index: expected %0d, actual %0d", want.index, rsp_alloc_index);
               errors++;
            end
            if (rsp_byte_offset !== want.offset) begin
               $error("byte_offset: expected %0d, actual %0d", want.offset, rsp_byte_offset);
               errors++;
            end
            if (rsp_used_count !== want.used) begin
               $error("used_count: expected %0d, actual %0d", want.used, rsp_used_count);
               errors++;
            end
            if (rsp_is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp_is_empty);
               errors++;
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   initial begin
      #15_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int seg_len [6];
      int fill_len;
      int pick;
      bit filling;
      logic [CSR_DATA_W-1:0] count_word;
      logic [IDX_W-1:0] idx;

      seg_len = '{120, 380, 80, 150, 150, 120};
      chunk_count_cfg = CHUNK_COUNT_RST;
      chunk_size_cfg = CHUNK_SIZE_RST;
      rebuild_links();

      // directed table
      add_typed(CMD_FREE, 8'd0, STATUS_NONE_USED, 0, 0, 0, 1'b1);
      add_typed(CMD_ALLOC, 8'd0, STATUS_OK, 0, 0, 1, 1'b0);
      add_typed(CMD_ALLOC, 8'd0, STATUS_OK, 1, 64, 2, 1'b0);
      add_typed(CMD_FREE, 8'd1, STATUS_OK, 0, 0, 1, 1'b0);
      add_req(CMD_ALLOC, 8'd0);
      add_req(CMD_NOP, 8'hFF);
      add_typed(CMD_REINIT, 8'd0, STATUS_OK, 0, 0, 0, 1'b1);
      add_csr(CSR_CHUNK_SIZE, 16'hFFFF);
      add_typed(CMD_ALLOC, 8'd0, STATUS_OK, 0, 0, 1, 1'b0);
      add_typed(CMD_ALLOC, 8'd0, STATUS_OK, 1, 65535, 2, 1'b0);
      add_csr(CSR_CHUNK_COUNT, 16'd2);
      add_typed(CMD_ALLOC, 8'd0, STATUS_FULL, 0, 0, 2, 1'b0);
      add_typed(CMD_FREE, 8'd2, STATUS_RANGE, 0, 0, 2, 1'b0);
      add_typed(CMD_FREE, 8'hFF, STATUS_RANGE, 0, 0, 2, 1'b0);
      add_req(CMD_FREE, 8'd1);
      add_req(CMD_ALLOC, 8'd0);
      add_csr(CSR_CHUNK_COUNT, 16'd0);
      add_typed(CMD_REINIT, 8'd0, STATUS_OK, 0, 0, 0, 1'b1);
      add_typed(CMD_ALLOC, 8'd0, STATUS_OK, 0, 0, 1, 1'b0);
      add_typed(CMD_ALLOC, 8'd0, STATUS_FULL, 0, 0, 1, 1'b0);
      add_typed(CMD_FREE, 8'd1, STATUS_RANGE, 0, 0, 1, 1'b0);
      add_typed(CMD_FREE, 8'd0, STATUS_OK, 0, 0, 0, 1'b1);
      add_typed(CMD_FREE, 8'd0, STATUS_NONE_USED, 0, 0, 0, 1'b1);
      add_csr(CSR_CHUNK_COUNT, 16'hFFFF);
      add_csr(CSR_CHUNK_SIZE, 16'd1);
      add_typed(CMD_REINIT, 8'd0, STATUS_OK, 0, 0, 0, 1'b1);
      add_req(CMD_ALLOC, 8'd0);
      add_req(CMD_NOP, 8'h55);
      add_req(CMD_FREE, 8'hAA);
      add_req(CMD_ALLOC, 8'd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            wait_idle();
            write_csr(script[i].csr_sel, script[i].csr_data);
            csr_write_enable <= 1'b0;
         end else begin
            send_request(script[i].cmd, script[i].idx, script[i].typed, script[i].want);
         end
      end

      // random segments, each with its own pool setting
      for (int seg = 0; seg < 6; seg++) begin
         tx_idle_pct = (seg < 2) ? 37 : (seg < 4) ? 69 : 0;
         rx_idle_pct = (seg < 2) ? 69 : (seg < 4) ? 37 : 0;
         count_word = CSR_DATA_W'($urandom);
         case (seg)
            0: count_word[CFG_CNT_W-1:0] = CFG_CNT_W'($urandom_range(1, 256));
            1: count_word[CFG_CNT_W-1:0] = 9'd256;
            2: count_word[CFG_CNT_W-1:0] = 9'd0;
            3: count_word[CFG_CNT_W-1:0] = CFG_CNT_W'($urandom_range(257, 511));
            4: count_word[CFG_CNT_W-1:0] = CFG_CNT_W'($urandom_range(2, 20));
            default: count_word[CFG_CNT_W-1:0] = CFG_CNT_W'($urandom_range(1, 256));
         endcase
         wait_idle();
         write_csr(CSR_CHUNK_COUNT, count_word);
         case (seg)
            1: write_csr(CSR_CHUNK_SIZE, 16'hFFFF);
            2: write_csr(CSR_CHUNK_SIZE, 16'd1);
            default: write_csr(CSR_CHUNK_SIZE, CSR_DATA_W'($urandom));
         endcase
         csr_write_enable <= 1'b0;
         if (seg == 1 || $urandom_range(0, 3) != 0) begin
            send_request(CMD_REINIT, IDX_W'($urandom), 1'b0, blank_reply);
         end
         fill_len = (seg == 1) ? 300 : seg_len[seg] / 2;
         filling = 1'b1;
         for (int i = 0; i < seg_len[seg]; i++) begin
            if (i == fill_len) filling = 1'b0;
            else if (i > fill_len && $urandom_range(0, 19) == 0) filling = !filling;
            pick = $urandom_range(0, 99);
            idx = IDX_W'($urandom);
            if (filling) begin
               if (pick < 88 || (pick < 92 && live_chunks.size() == 0)) begin
                  send_request(CMD_ALLOC, idx, 1'b0, blank_reply);
               end else if (pick < 92) begin
                  idx = IDX_W'(live_chunks[$urandom_range(0, live_chunks.size() - 1)]);
                  send_request(CMD_FREE, idx, 1'b0, blank_reply);
               end else if (pick < 97) begin
                  send_request(CMD_FREE, idx, 1'b0, blank_reply);
               end else begin
                  send_request(CMD_NOP, idx, 1'b0, blank_reply);
               end
            end else begin
               if (pick < 20 || (pick < 78 && live_chunks.size() == 0)) begin
                  send_request(CMD_ALLOC, idx, 1'b0, blank_reply);
               end else if (pick < 78) begin
                  idx = IDX_W'(live_chunks[$urandom_range(0, live_chunks.size() - 1)]);
                  send_request(CMD_FREE, idx, 1'b0, blank_reply);
               end else if (pick < 88) begin
                  send_request(CMD_FREE, idx, 1'b0, blank_reply);
               end else if (pick < 94) begin
                  send_request(CMD_NOP, idx, 1'b0, blank_reply);
               end else begin
                  send_request(CMD_REINIT, idx, 1'b0, blank_reply);
               end
            end
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
